FILE: rtl/b89_pkg.sv
package b89_pkg;

	// character code width and the radix of the digits
	localparam int CHAR_W = 7;
	localparam int RADIX = 89;
	// a remainder is always below the radix
	localparam int REM_W = 7;
	// dividend bits consumed per division cycle
	localparam int STEP_BITS = 8;

	// digit alphabet, first character is digit zero
	localparam int ALPHA_LEN = 89;
	localparam logic [8*ALPHA_LEN-1:0] ALPHABET =
		{"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz",
		 "!<#$%&>()*+,-./[?]^_`{|}~@\\"};

	// map one base-89 digit to its ascii code
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [REM_W-1:0] digit);
		logic [7:0] code;
		code = ALPHABET[8*(ALPHA_LEN-1-int'(digit)) +: 8];
		return code[CHAR_W-1:0];
	endfunction

endpackage

FILE: rtl/b89_value_if.sv
interface b89_value_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

FILE: rtl/b89_char_if.sv
interface b89_char_if;
	import b89_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink (input valid, input digit_char, input last, output ready);
endinterface

FILE: rtl/base89_text_encoder.sv
// channel   dir   payload                      per word
// values    in    value [VALUE_WIDTH-1:0]      one number to convert
// chars     out   digit_char [6:0], last       one character, msd first
//
// each division by 89 walks every dividend byte, one dividend byte per cycle,
// through an 8-step restoring divider with a 7-bit remainder.
// arst_n clears the control state; the digit store is not cleared.
// a stalled output word holds in the output register; emission waits for it,
// and a new value is taken while the final character still waits.
module base89_text_encoder #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS = 5
) (
	input logic         clk,
	input logic         arst_n,
	b89_value_if.sink   values,
	b89_char_if.source  chars
);
	import b89_pkg::*;

	localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W = CHUNKS * STEP_BITS;
	localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [PAD_W-1:0]    work_q;
	logic [REM_W-1:0]    rem_q;
	logic [CHUNK_W-1:0]  chunk_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic                oval_q;
	logic [CHAR_W-1:0]   ochar_q;
	logic                olast_q;
	logic [REM_W-1:0]    store_q [MAX_DIGITS];

	logic [STEP_BITS-1:0] byte_in;
	logic [STEP_BITS-1:0] qbyte;
	logic [REM_W-1:0]     rem_next;
	logic [PAD_W-1:0]     work_next;
	logic                 div_done;
	logic                 last_digit;
	logic                 out_free;
	logic                 emit_go;

	// one dividend byte through eight restoring steps
	always_comb begin
		logic [REM_W:0] t;
		logic [REM_W-1:0] r;
		r = rem_q;
		qbyte = '0;
		byte_in = work_q[PAD_W-1 -: STEP_BITS];
		for (int j = STEP_BITS - 1; j >= 0; j--) begin
			t = {r, byte_in[j]};
			if (t >= (REM_W+1)'(RADIX)) begin
				t = t - (REM_W+1)'(RADIX);
				qbyte[j] = 1'b1;
			end
			r = t[REM_W-1:0];
		end
		rem_next = r;
		work_next = (work_q << STEP_BITS) | PAD_W'(qbyte);
	end

	assign div_done = (chunk_q == CHUNK_W'(CHUNKS - 1));
	assign last_digit = (work_next == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));
	assign out_free = !oval_q || chars.ready;
	// a character word is loaded into the output register this cycle
	assign emit_go = (state_q == ST_EMIT) && out_free;

	assign values.ready = (state_q == ST_IDLE);
	assign chars.valid = oval_q;
	assign chars.digit_char = ochar_q;
	assign chars.last = olast_q;

	// digit store, least significant digit at entry zero
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			store_q[cnt_q[IDX_W-1:0]] <= rem_next;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			work_q <= '0;
			rem_q <= '0;
			chunk_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			oval_q <= 1'b0;
			ochar_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (chars.ready && !emit_go) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (values.valid) begin
						work_q <= PAD_W'(values.value);
						rem_q <= '0;
						chunk_q <= '0;
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					work_q <= work_next;
					if (div_done) begin
						// digit finished: start the next division or emit
						rem_q <= '0;
						chunk_q <= '0;
						if (last_digit) begin
							idx_q <= cnt_q[IDX_W-1:0];
							state_q <= ST_EMIT;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						rem_q <= rem_next;
						chunk_q <= chunk_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						oval_q <= 1'b1;
						ochar_q <= digit_to_char(store_q[idx_q]);
						olast_q <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
